// ----- hw/rtl/hsb_pkg.sv -----
`timescale 1ns / 1ps

package hsb_pkg;

    // Channel and result widths
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 15;

    // Hue fraction quotient: 3840 * |delta| / dif never exceeds 3840
    localparam int HUE_Q_BITS   = 12;
    localparam int HUE_SCALE    = 60 * 64;

    // Partial remainder widths of the two divisions
    localparam int HREM_W       = CHANNEL_BITS + HUE_Q_BITS;
    localparam int SREM_W       = 2 * CHANNEL_BITS;

    // One quotient bit of each division per cell
    localparam int STAGES       = (HUE_Q_BITS > CHANNEL_BITS) ? HUE_Q_BITS : CHANNEL_BITS;

    // Input register, cell row, output register
    localparam int PIPE_LATENCY = STAGES + 2;

    // Sector base hues in 1/64 degree
    localparam logic [HUE_BITS-1:0] HUE_BASE_RED   = HUE_BITS'(0);
    localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN = HUE_BITS'(120 * 64);
    localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE  = HUE_BITS'(240 * 64);
    localparam logic [HUE_BITS-1:0] HUE_BASE_WRAP  = HUE_BITS'(360 * 64);
    localparam logic [HUE_BITS-1:0] HUE_MAX        = HUE_BITS'(360 * 64 - 1);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsb_t;

    // Data handed from cell to cell
    typedef struct packed {
        logic [HREM_W-1:0]       hue_rem;
        logic [SREM_W-1:0]       sat_rem;
        logic [CHANNEL_BITS-1:0] dif;
        logic [CHANNEL_BITS-1:0] mx;
        logic [STAGES-1:0]       hue_q;
        logic [STAGES-1:0]       sat_q;
        logic [HUE_BITS-1:0]     base;
        logic                    neg;
        logic                    flat;
    } cell_data_t;

endpackage

// ----- hw/rtl/hsb_front.sv -----
`timescale 1ns / 1ps

module hsb_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsb_pkg::pixel_t     in_pixel,
    output logic                out_valid,
    output hsb_pkg::cell_data_t out_data
);
    import hsb_pkg::*;

    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] mn;
    logic [CHANNEL_BITS-1:0] pos;
    logic [CHANNEL_BITS-1:0] negv;
    logic [CHANNEL_BITS:0]   delta;
    logic [CHANNEL_BITS-1:0] mag;
    logic [HUE_BITS-1:0]     base;
    logic                    valid_reg;
    cell_data_t              data_reg;
    cell_data_t              data_next;

    // Find largest and smallest channel
    always_comb
    begin
        mx = in_pixel.red;
        mn = in_pixel.red;
        if (in_pixel.green > mx) mx = in_pixel.green;
        if (in_pixel.blue > mx)  mx = in_pixel.blue;
        if (in_pixel.green < mn) mn = in_pixel.green;
        if (in_pixel.blue < mn)  mn = in_pixel.blue;
    end

    // Pick sector: green first, then blue, then red
    always_comb
    begin
        if (in_pixel.green == mx)
        begin
            base = HUE_BASE_GREEN;
            pos  = in_pixel.blue;
            negv = in_pixel.red;
        end
        else if (in_pixel.blue == mx)
        begin
            base = HUE_BASE_BLUE;
            pos  = in_pixel.red;
            negv = in_pixel.green;
        end
        else if (in_pixel.blue > in_pixel.green)
        begin
            base = HUE_BASE_WRAP;
            pos  = in_pixel.green;
            negv = in_pixel.blue;
        end
        else
        begin
            base = HUE_BASE_RED;
            pos  = in_pixel.green;
            negv = in_pixel.blue;
        end
        delta = {1'b0, pos} - {1'b0, negv};
        mag   = delta[CHANNEL_BITS] ? CHANNEL_BITS'(-delta) : delta[CHANNEL_BITS-1:0];
    end

    // Prepare both dividends
    always_comb
    begin
        data_next.dif     = mx - mn;
        data_next.mx      = mx;
        data_next.hue_rem = HREM_W'(mag) * HREM_W'(HUE_SCALE);
        data_next.sat_rem = (SREM_W'(data_next.dif) << CHANNEL_BITS) - SREM_W'(data_next.dif);
        data_next.hue_q   = '0;
        data_next.sat_q   = '0;
        data_next.base    = base;
        data_next.neg     = delta[CHANNEL_BITS];
        data_next.flat    = (mx == mn);
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Capture beat
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/hsb_cell.sv -----
`timescale 1ns / 1ps

module hsb_cell #(
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hsb_pkg::cell_data_t in_data,
    output logic                out_valid,
    output hsb_pkg::cell_data_t out_data
);
    import hsb_pkg::*;

    logic       hue_bit;
    logic       sat_bit;
    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    // Settle one quotient bit of hue and of saturation
    always_comb
    begin
        hue_bit   = (in_data.hue_rem >> SHIFT) >= HREM_W'(in_data.dif);
        sat_bit   = (in_data.sat_rem >> SHIFT) >= SREM_W'(in_data.mx);
        data_next = in_data;
        if (hue_bit)
            data_next.hue_rem = in_data.hue_rem - (HREM_W'(in_data.dif) << SHIFT);
        if (sat_bit)
            data_next.sat_rem = in_data.sat_rem - (SREM_W'(in_data.mx) << SHIFT);
        data_next.hue_q = {in_data.hue_q[STAGES-2:0], hue_bit};
        data_next.sat_q = {in_data.sat_q[STAGES-2:0], sat_bit};
    end

    // Advance valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Hand beat to the next cell
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/rgb_to_hsb_converter.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------
// pixel in | start (busy always 0)| pixel.red, pixel.green, pixel.blue
// result   | done, one cycle      | result.hue, result.saturation,
//          |                      | result.brightness
//
// One pixel is taken every cycle; each result passes through the input
// register, 12 divider cells and the output register. The cell row does
// one quotient bit of hue and of saturation per cell, so its length sets
// the latency. Reset clears only the valid flags. The receiver cannot
// stall: done lasts one cycle per result.

module rgb_to_hsb_converter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  hsb_pkg::pixel_t pixel,
    output logic            done,
    output hsb_pkg::hsb_t   result
);
    import hsb_pkg::*;

    logic       valid_chain [STAGES+1];
    cell_data_t data_chain  [STAGES+1];
    cell_data_t last;
    logic [HUE_Q_BITS-1:0] frac;
    logic       round_up;
    logic       done_reg;
    hsb_t       result_reg;
    hsb_t       result_next;

    assign busy = 1'b0;

    // Prepare dividends
    hsb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_pixel (pixel),
        .out_valid(valid_chain[0]),
        .out_data (data_chain[0])
    );

    // Row of divider cells, most significant quotient bit first
    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        hsb_cell #(
            .SHIFT(STAGES - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_chain[k]),
            .in_data  (data_chain[k]),
            .out_valid(valid_chain[k+1]),
            .out_data (data_chain[k+1])
        );
    end

    // Apply sector base and sign; gray and black give zero hue and saturation
    always_comb
    begin
        last     = data_chain[STAGES];
        frac     = last.hue_q[HUE_Q_BITS-1:0];
        round_up = (last.hue_rem != '0);
        if (last.neg)
            result_next.hue = last.base - HUE_BITS'(frac) - HUE_BITS'(round_up);
        else
            result_next.hue = last.base + HUE_BITS'(frac);
        result_next.saturation = last.sat_q[CHANNEL_BITS-1:0];
        result_next.brightness = last.mx;
        if (last.flat)
        begin
            result_next.hue        = '0;
            result_next.saturation = '0;
        end
    end

    // Drive result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_chain[STAGES];
    end

    // Hold result beat
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/hsb_checker.sv -----
`timescale 1ns / 1ps

module hsb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input hsb_pkg::pixel_t pixel,
    input logic            done,
    input hsb_pkg::hsb_t   result
);
    import hsb_pkg::*;

    // Every start beat yields a result a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("result missing after start beat");

    // No result without a start beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##PIPE_LATENCY !done)
        else $error("result without start beat");

    // Hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hue <= HUE_MAX))
        else $error("hue out of range");

    // Black pixel gives all zeros
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.brightness == '0) |->
            (result.hue == '0 && result.saturation == '0))
        else $error("black pixel not all zero");

    // Grey input gives zero hue and saturation
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel.red == pixel.green && pixel.green == pixel.blue) |->
            ##PIPE_LATENCY (result.hue == '0 && result.saturation == '0))
        else $error("grey pixel has colour");

endmodule

bind rgb_to_hsb_converter hsb_checker u_hsb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .pixel (pixel),
    .done  (done),
    .result(result)
);

// ----- test/rgb_to_hsb_converter_tb.sv -----
`timescale 1ns / 1ps

module rgb_to_hsb_converter_tb;

    import hsb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 600;
    localparam int CHAN_TOP    = (1 << CHANNEL_BITS) - 1;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    // One queued pixel with its sender behaviour
    typedef struct {
        pixel_t      px;
        bit          drain;
        int unsigned idle_pct;
    } pixel_req_t;

    logic   clk    = 1'b0;
    logic   rst_n  = 1'b0;
    logic   start  = 1'b0;
    pixel_t pixel  = '0;
    logic   busy;
    logic   done;
    hsb_t   result;

    pixel_req_t pixel_backlog[$];
    hsb_t       hsb_due_q[$];

    logic        beat_taken = 1'b0;
    logic        nxt_start;
    pixel_t      nxt_px;
    pixel_req_t  head_req;
    int unsigned quiet_cycles = 0;
    int unsigned error_count  = 0;
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned gray_seen    = 0;
    int unsigned black_seen   = 0;

    rgb_to_hsb_converter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Work out hue, saturation and brightness of one pixel
    function automatic hsb_t rgb_to_hsb(pixel_t px);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   dif;
        int   base;
        int   delta;
        int   num;
        hsb_t o;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        o  = '0;
        if (mx == 0)
        begin
            return o;
        end
        o.brightness = chan_t'(mx);
        dif = mx - mn;
        if (dif != 0)
        begin
            // green wins ties, then blue, then red
            if (g == mx)
            begin
                base  = 120;
                delta = b - r;
            end
            else if (b == mx)
            begin
                base  = 240;
                delta = r - g;
            end
            else if (b > g)
            begin
                base  = 360;
                delta = g - b;
            end
            else
            begin
                base  = 0;
                delta = g - b;
            end
            num          = base * 64 * dif + 3840 * delta;
            o.hue        = HUE_BITS'(num / dif);
            o.saturation = chan_t'((dif * CHAN_TOP) / mx);
        end
        return o;
    endfunction

    // Random pixel leaning on gray, tied and extreme channels
    function automatic pixel_t shaped_pixel();
        pixel_t px;
        chan_t  v;
        chan_t  w;
        px = pixel_t'($urandom);
        case ($urandom_range(9))
            0:
            begin
                v        = chan_t'($urandom_range(CHAN_TOP));
                px.red   = v;
                px.green = v;
                px.blue  = v;
            end
            1, 2:
            begin
                v = chan_t'($urandom_range(CHAN_TOP, 1));
                w = chan_t'($urandom_range(v));
                case ($urandom_range(2))
                    0:       px = '{red: v, green: v, blue: w};
                    1:       px = '{red: w, green: v, blue: v};
                    default: px = '{red: v, green: w, blue: v};
                endcase
            end
            3:
            begin
                px.red   = ($urandom_range(1)) ? chan_t'(CHAN_TOP) : chan_t'($urandom_range(1));
                px.green = ($urandom_range(1)) ? chan_t'(CHAN_TOP - $urandom_range(1)) : '0;
                px.blue  = ($urandom_range(1)) ? chan_t'($urandom) : chan_t'(CHAN_TOP);
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic queue_pixel(input int r, input int g, input int b,
                               input bit drain, input int unsigned idle_pct);
        pixel_req_t req;
        req.px       = '{red: chan_t'(r), green: chan_t'(g), blue: chan_t'(b)};
        req.drain    = drain;
        req.idle_pct = idle_pct;
        pixel_backlog.push_back(req);
    endtask

    // Driver: hold an unaccepted beat, else present the next pixel or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !beat_taken))
        begin
            nxt_start = 1'b0;
            nxt_px    = pixel;
            if (pixel_backlog.size() != 0)
            begin
                if (pixel_backlog[0].drain && hsb_due_q.size() != 0)
                    nxt_start = 1'b0;
                else if ($urandom_range(99) < pixel_backlog[0].idle_pct)
                    nxt_start = 1'b0;
                else
                begin
                    head_req  = pixel_backlog.pop_front();
                    nxt_start = 1'b1;
                    nxt_px    = head_req.px;
                end
            end
            start <= nxt_start;
            pixel <= nxt_px;
        end
    end

    // Monitor: log accepted beats and check each result strobe
    always @(posedge clk)
    begin
        beat_taken <= start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                hsb_due_q.push_back(rgb_to_hsb(pixel));
                beats_sent++;
            end
            if (done)
            begin
                results_seen++;
                if (hsb_due_q.size() == 0)
                begin
                    $error("unexpected result: hue %0d saturation %0d brightness %0d",
                           result.hue, result.saturation, result.brightness);
                    error_count++;
                end
                else
                begin
                    if (result.hue != hsb_due_q[0].hue)
                    begin
                        $error("hue mismatch: expected %0d, got %0d",
                               hsb_due_q[0].hue, result.hue);
                        error_count++;
                    end
                    if (result.saturation != hsb_due_q[0].saturation)
                    begin
                        $error("saturation mismatch: expected %0d, got %0d",
                               hsb_due_q[0].saturation, result.saturation);
                        error_count++;
                    end
                    if (result.brightness != hsb_due_q[0].brightness)
                    begin
                        $error("brightness mismatch: expected %0d, got %0d",
                               hsb_due_q[0].brightness, result.brightness);
                        error_count++;
                    end
                    if (hsb_due_q[0].brightness == 0)
                        black_seen++;
                    else if (hsb_due_q[0].saturation == 0)
                        gray_seen++;
                    void'(hsb_due_q.pop_front());
                end
            end
        end
    end

    // Watchdog: stop when neither side moves a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned idle_plan[3];
        pixel_t      px;
        idle_plan = '{20, 81, 0};

        // Directed: black, gray, primaries, ties and the hue wrap
        queue_pixel(0, 0, 0, 1'b0, 20);
        queue_pixel(255, 255, 255, 1'b0, 20);
        queue_pixel(1, 1, 1, 1'b0, 20);
        queue_pixel(128, 128, 128, 1'b0, 20);
        queue_pixel(255, 0, 0, 1'b0, 20);
        queue_pixel(0, 255, 0, 1'b0, 20);
        queue_pixel(0, 0, 255, 1'b0, 20);
        queue_pixel(1, 0, 0, 1'b0, 20);
        queue_pixel(0, 1, 0, 1'b0, 20);
        queue_pixel(0, 0, 1, 1'b0, 20);
        queue_pixel(255, 255, 0, 1'b0, 20);
        queue_pixel(0, 255, 255, 1'b0, 20);
        queue_pixel(255, 0, 255, 1'b0, 20);
        queue_pixel(255, 0, 1, 1'b0, 20);
        queue_pixel(255, 1, 0, 1'b0, 20);
        queue_pixel(200, 10, 10, 1'b0, 20);
        queue_pixel(255, 254, 0, 1'b0, 20);
        queue_pixel(0, 254, 255, 1'b0, 20);
        queue_pixel(254, 0, 255, 1'b0, 20);
        queue_pixel(8'hAA, 8'h55, 8'hAA, 1'b0, 20);
        queue_pixel(8'h55, 8'hAA, 8'h55, 1'b0, 20);
        queue_pixel(255, 1, 254, 1'b0, 20);
        queue_pixel(1, 255, 254, 1'b0, 20);

        // Random: three sender phases, each opened after a full drain
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                px = shaped_pixel();
                queue_pixel(px.red, px.green, px.blue,
                            (i == 0) || (i == PHASE_ITEMS / 2), idle_plan[ph]);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the backlog to empty and every result to arrive
        while (pixel_backlog.size() != 0 || start || hsb_due_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (hsb_due_q.size() != 0)
        begin
            $error("%0d results never arrived", hsb_due_q.size());
            error_count++;
        end
        $display("converted %0d pixels, checked %0d results (%0d gray, %0d black)",
                 beats_sent, results_seen, gray_seen, black_seen);
        $display("sender idle at 20%%, 81%% and 0%% of cycles, with drains between phases");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
